>>> src/lkv_pkg.sv
// Shared types and constants for the LRU key/value cache.
package lkv_pkg;

   // Operation codes carried on req_mode
   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   // Field widths fixed by the interface
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   // Capacity after reset and the value a get miss returns
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
   localparam logic [VAL_W-1:0] MISS_VALUE     = 32'hFFFF_FFFF;

   // Summary flags from the table search
   typedef struct packed {
      logic hit;
      logic victim_found;
      logic free_found;
   } lookup_type;

endpackage

>>> src/lru_key_value_cache.sv
// Top level of the fully associative LRU key/value cache.
// One request (get or put) is taken every clock cycle; busy stays low. A request
// accepted on start is registered, then searched and applied to the table in the
// following cycle, and its response is registered before it strobes on rsp_valid.
// The response cannot be stalled. The table lives in flip-flops, so the store is
// empty right after reset with no clearing pass. csr_data sets the capacity
// (values above ENTRIES act as ENTRIES); write it only while no request is in flight.
module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_mode,
   input  logic signed [31:0]          req_key,
   input  logic signed [31:0]          req_value,
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic signed [31:0]          rsp_read_value,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lkv_pkg::CAP_W-1:0]   csr_data
);

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (OCC_W > lkv_pkg::CAP_W) ? OCC_W : lkv_pkg::CAP_W;

   // Request stage
   logic                       req_valid_ff;
   logic                       req_mode_ff;
   logic [lkv_pkg::KEY_W-1:0]  req_key_ff;
   logic [lkv_pkg::VAL_W-1:0]  req_value_ff;

   // Table state
   logic [ENTRIES-1:0]                     valid_ff,  valid_in;
   logic [ENTRIES-1:0][lkv_pkg::KEY_W-1:0] keys_ff,   keys_in;
   logic [ENTRIES-1:0][lkv_pkg::VAL_W-1:0] values_ff, values_in;
   logic [ENTRIES-1:0][RANK_W-1:0]         ranks_ff,  ranks_in;
   logic [OCC_W-1:0]                       occ_ff,    occ_in;
   logic [lkv_pkg::CAP_W-1:0]              capacity_ff;

   // Response stage
   logic                       rsp_valid_ff;
   logic                       rsp_hit_ff,        rsp_hit_in;
   logic [lkv_pkg::VAL_W-1:0]  rsp_read_value_ff, rsp_read_value_in;

   // Search results
   logic [ENTRIES-1:0]         hit_vec, victim_vec, free_vec;
   logic [RANK_W-1:0]          hit_rank;
   logic [lkv_pkg::VAL_W-1:0]  hit_value;
   lkv_pkg::lookup_type        flags;
   logic [RANK_W-1:0]          victim_rank;
   logic [CMP_W-1:0]           eff_cap;
   logic                       full;
   logic [ENTRIES-1:0]         slot_vec;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   assign victim_rank = RANK_W'(occ_ff - OCC_W'(1));

   // Clamp capacity to the table size
   always_comb begin
      if (CMP_W'(capacity_ff) > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = CMP_W'(capacity_ff);
      end
   end
   assign full = CMP_W'(occ_ff) >= eff_cap;

   lkv_lookup #(
      .ENTRIES (ENTRIES),
      .RANK_W  (RANK_W)
   ) u_lookup (
      .valid       (valid_ff),
      .keys        (keys_ff),
      .values      (values_ff),
      .ranks       (ranks_ff),
      .key         (req_key_ff),
      .victim_rank (victim_rank),
      .hit_vec     (hit_vec),
      .victim_vec  (victim_vec),
      .free_vec    (free_vec),
      .hit_rank    (hit_rank),
      .hit_value   (hit_value),
      .flags       (flags)
   );

   // Register the incoming beat
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
      req_mode_ff  <= req_mode;
      req_key_ff   <= req_key;
      req_value_ff <= req_value;
   end

   // Hold the capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lkv_pkg::CAPACITY_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_data;
      end
   end

   // Pick the slot a missing put lands in: oldest if full, else lowest empty
   always_comb begin
      if (full) begin
         slot_vec = (occ_ff != '0 && flags.victim_found) ? victim_vec : '0;
      end else begin
         slot_vec = flags.free_found ? free_vec : '0;
      end
   end

   // Apply the staged request to the table and form the response
   always_comb begin
      valid_in          = valid_ff;
      keys_in           = keys_ff;
      values_in         = values_ff;
      ranks_in          = ranks_ff;
      occ_in            = occ_ff;
      rsp_hit_in        = flags.hit;
      rsp_read_value_in = '0;
      if (req_valid_ff) begin
         if (flags.hit) begin
            // Touch: younger entries age by one, hit slot becomes newest
            for (int i = 0; i < ENTRIES; i++) begin
               if (hit_vec[i]) begin
                  ranks_in[i] = '0;
                  if (req_mode_ff == lkv_pkg::MODE_PUT) begin
                     values_in[i] = req_value_ff;
                  end
               end else if (valid_ff[i] && ranks_ff[i] < hit_rank) begin
                  ranks_in[i] = ranks_ff[i] + RANK_W'(1);
               end
            end
            if (req_mode_ff == lkv_pkg::MODE_GET) begin
               rsp_read_value_in = hit_value;
            end
         end else if (req_mode_ff == lkv_pkg::MODE_GET) begin
            rsp_read_value_in = lkv_pkg::MISS_VALUE;
         end else if (|slot_vec) begin
            // Insert: every other valid entry ages, new entry is newest
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_vec[i]) begin
                  valid_in[i]  = 1'b1;
                  keys_in[i]   = req_key_ff;
                  values_in[i] = req_value_ff;
                  ranks_in[i]  = '0;
               end else if (valid_ff[i]) begin
                  ranks_in[i] = ranks_ff[i] + RANK_W'(1);
               end
            end
            if (!full) begin
               occ_in = occ_ff + OCC_W'(1);
            end
         end
      end
   end

   // Table control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ranks_ff <= '0;
         occ_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         ranks_ff <= ranks_in;
         occ_ff   <= occ_in;
      end
   end

   // Table payload
   always_ff @(posedge clock) begin
      keys_ff   <= keys_in;
      values_ff <= values_in;
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
      rsp_hit_ff        <= rsp_hit_in;
      rsp_read_value_ff <= rsp_read_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_read_value_ff;

   // A start beat produces a response through the request and response registers
   assert property (@(posedge clock) disable iff (reset) start |=> ##1 rsp_valid)
      else $error("response missing two cycles after start");

   // The fill count tracks the valid bits
   assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(occ_ff))
      else $error("occupancy out of step with valid entries");

   // A missing put never grows the table past its clamped capacity
   assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !flags.hit && full) |=> occ_ff == $past(occ_ff))
      else $error("occupancy grew while full");

endmodule

>>> src/lkv_lookup.sv
// Parallel key compare, victim search and free-slot search over the table.
module lkv_lookup #(
   parameter int ENTRIES = 16,
   parameter int RANK_W  = 4
) (
   input  logic [ENTRIES-1:0]                    valid,
   input  logic [ENTRIES-1:0][lkv_pkg::KEY_W-1:0] keys,
   input  logic [ENTRIES-1:0][lkv_pkg::VAL_W-1:0] values,
   input  logic [ENTRIES-1:0][RANK_W-1:0]         ranks,
   input  logic [lkv_pkg::KEY_W-1:0]              key,
   input  logic [RANK_W-1:0]                      victim_rank,
   output logic [ENTRIES-1:0]                     hit_vec,
   output logic [ENTRIES-1:0]                     victim_vec,
   output logic [ENTRIES-1:0]                     free_vec,
   output logic [RANK_W-1:0]                      hit_rank,
   output logic [lkv_pkg::VAL_W-1:0]              hit_value,
   output lkv_pkg::lookup_type                    flags
);

   logic free_seen;

   // Compare every slot at once; keys are unique so at most one hits
   always_comb begin
      hit_vec   = '0;
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = valid[i] && (keys[i] == key);
         hit_rank   = hit_rank  | (ranks[i]  & {RANK_W{hit_vec[i]}});
         hit_value  = hit_value | (values[i] & {lkv_pkg::VAL_W{hit_vec[i]}});
      end
   end

   // Find the oldest valid slot and the lowest empty slot
   always_comb begin
      victim_vec = '0;
      free_vec   = '0;
      free_seen  = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (valid[i] && (ranks[i] == victim_rank)) begin
            victim_vec    = '0;
            victim_vec[i] = 1'b1;
         end
         if (!valid[i] && !free_seen) begin
            free_vec[i] = 1'b1;
            free_seen   = 1'b1;
         end
      end
   end

   assign flags.hit          = |hit_vec;
   assign flags.victim_found = |victim_vec;
   assign flags.free_found   = free_seen;

endmodule
